[rtl/rmse_pkg.sv]
// ----------------------------------------------------------------------------
// rmse_pkg
// Shared widths and constants for the block RMS envelope.
// ----------------------------------------------------------------------------
`default_nettype none

package rmse_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int LEVEL_W         = 16;
  localparam int SPW_W           = 16;
  localparam int DEF_WINDOW_BITS = 16;

  localparam logic [SPW_W-1:0] SPW_RESET = 16'd1200;

  localparam int SQ_W      = 32;
  localparam int MEAN_W    = 31;
  localparam int SQRT_OP_W = 40;
  localparam int ROOT_W    = 20;
  localparam int SCALE_W   = 22;

  // ceil(2^26 * 20 / 48): exact floor(root * 20 / 48) for any 20-bit root
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 26;
  localparam logic [RECIP_W-1:0] LEVEL_RECIP = 25'd27962027;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

endpackage

`default_nettype wire

[rtl/rmse_cmpsub.sv]
// ----------------------------------------------------------------------------
// rmse_cmpsub
// Shared compare-and-subtract unit for the divide and square-root steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rmse_cmpsub #(
  parameter int W = 22
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] diff,
  output logic              ge
);

  logic [W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[W-1:0];
  assign ge   = ~wide[W];

endmodule

`default_nettype wire

[rtl/block_rms_envelope.sv]
// ----------------------------------------------------------------------------
// block_rms_envelope
// RMS loudness per window of signed 16-bit PCM samples, in Q0.16 of 0.3 FS.
// ----------------------------------------------------------------------------
// A sample that does not close a window passes through accept, square and
// accumulate. A sample that closes a window, by count or by tlast, adds the
// level calculation on one shared compare-subtract unit:
// max(WINDOW_BITS+31, 40) divide steps for the mean and 20 square-root steps,
// then one step that scales the root by 20/48 with a reciprocal multiply, and
// one output load. in_tready is low while a sample is in work. One result
// waits in the output register while the next sample is taken; a second
// result holds the block until it is free. samples_per_window of 0 acts as 1.
`default_nettype none

module block_rms_envelope #(
  parameter int WINDOW_BITS = rmse_pkg::DEF_WINDOW_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [rmse_pkg::SPW_W-1:0]    cfg_wr_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [rmse_pkg::SAMPLE_W-1:0] in_tdata,   // [15:0] sample
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [rmse_pkg::LEVEL_W-1:0]  out_tdata,  // [15:0] level
  output logic                               out_tlast
);

  import rmse_pkg::*;

  localparam int SUM_W  = WINDOW_BITS + 31;
  localparam int OP_W   = (SUM_W > SQRT_OP_W) ? SUM_W : SQRT_OP_W;
  localparam int U_W    = (WINDOW_BITS + 1 > SCALE_W) ? WINDOW_BITS + 1 : SCALE_W;
  localparam int CMP_W  = (WINDOW_BITS > SPW_W) ? WINDOW_BITS : SPW_W;
  localparam int STEP_W = $clog2(OP_W);
  localparam int PROD_W = ROOT_W + RECIP_W;
  localparam int LVLQ_W = PROD_W - RECIP_SHIFT;

  localparam logic [WINDOW_BITS-1:0] COUNT_MAX = {WINDOW_BITS{1'b1}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SQRT  = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [SPW_W-1:0]       spw_r, spw_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [WINDOW_BITS-1:0] cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]     out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [SAMPLE_W-1:0]    mag_r, mag_nxt;
  logic                   last_r, last_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic [OP_W-1:0]        dvd_r, dvd_nxt;
  logic [U_W-1:0]         rem_r, rem_nxt;
  logic [U_W-1:0]         dvs_r, dvs_nxt;
  logic [U_W-1:0]         root_r, root_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [LEVEL_W-1:0]     level_r, level_nxt;

  logic [U_W-1:0]         unit_a, unit_b, unit_diff;
  logic                   unit_ge;

  logic                   in_fire, out_fire;
  logic [SAMPLE_W-1:0]    sample_neg;
  logic [SUM_W-1:0]       sum_add;
  logic [WINDOW_BITS-1:0] cnt_add;
  logic [SPW_W-1:0]       limit;
  logic                   close_win;
  logic [OP_W-1:0]        quot_fin;
  logic [MEAN_W-1:0]      mean;
  logic [SQRT_OP_W-1:0]   sqrt_op;
  logic [U_W-1:0]         root_fin;
  logic [PROD_W-1:0]      scale_prod;
  logic [LVLQ_W-1:0]      level_q;

  rmse_cmpsub #(
    .W (U_W)
  ) u_cmpsub (
    .a    (unit_a),
    .b    (unit_b),
    .diff (unit_diff),
    .ge   (unit_ge)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_fire   = out_valid_r & out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign sample_neg = ~in_tdata + 1'b1;
  assign sum_add    = sum_r + SUM_W'(sq_r);
  assign cnt_add    = cnt_r + 1'b1;
  assign limit      = (spw_r == '0) ? SPW_W'(1) : spw_r;
  assign close_win  = (CMP_W'(cnt_add) >= CMP_W'(limit)) || (cnt_add == COUNT_MAX) || last_r;
  assign quot_fin   = {dvd_r[OP_W-2:0], unit_ge};
  assign mean       = quot_fin[MEAN_W-1:0];
  assign sqrt_op    = {1'b0, mean, 8'b0};
  assign root_fin   = {root_r[U_W-2:0], unit_ge};
  assign scale_prod = PROD_W'(root_r[ROOT_W-1:0]) * PROD_W'(LEVEL_RECIP);
  assign level_q    = scale_prod[PROD_W-1:RECIP_SHIFT];

  always_comb begin
    unit_a = '0;
    unit_b = '0;
    unique case (state_r)
      S_DIV: begin
        unit_a = {rem_r[U_W-2:0], dvd_r[OP_W-1]};
        unit_b = dvs_r;
      end
      S_SQRT: begin
        unit_a = {rem_r[U_W-3:0], dvd_r[OP_W-1 -: 2]};
        unit_b = {root_r[U_W-3:0], 2'b01};
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    spw_nxt       = cfg_wr_en ? cfg_wr_data : spw_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    mag_nxt       = mag_r;
    last_nxt      = last_r;
    sq_nxt        = sq_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    level_nxt     = level_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mag_nxt   = in_tdata[SAMPLE_W-1] ? sample_neg : in_tdata;
          last_nxt  = in_tlast;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        sq_nxt    = SQ_W'(mag_r) * SQ_W'(mag_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (close_win) begin
          dvd_nxt   = OP_W'(sum_add);
          rem_nxt   = '0;
          dvs_nxt   = U_W'(cnt_add);
          step_nxt  = STEP_W'(OP_W - 1);
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          sum_nxt   = sum_add;
          cnt_nxt   = cnt_add;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        rem_nxt  = unit_ge ? unit_diff : unit_a;
        dvd_nxt  = quot_fin;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          dvd_nxt   = OP_W'(sqrt_op) << (OP_W - SQRT_OP_W);
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(ROOT_W - 1);
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        rem_nxt  = unit_ge ? unit_diff : unit_a;
        root_nxt = root_fin;
        dvd_nxt  = dvd_r << 2;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        level_nxt = (level_q > LVLQ_W'(LEVEL_MAX)) ? LEVEL_MAX : level_q[LEVEL_W-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = level_r;
          out_last_nxt  = last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spw_r       <= SPW_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spw_r       <= spw_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    mag_r      <= mag_nxt;
    last_r     <= last_nxt;
    sq_r       <= sq_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    root_r     <= root_nxt;
    step_r     <= step_nxt;
    level_r    <= level_nxt;
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted while a sample is in work");

  a_empty_window_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (sum_r == '0))
    else $error("sum of squares left over in an empty window");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < dvs_r))
    else $error("divide remainder not below divisor");

  a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output load");
`endif

endmodule

`default_nettype wire
